// ===== rtl/core/hcbd_pkg.sv =====
// Shared types, constants and character helpers for the chunked body decoder.
package hcbd_pkg;

	localparam int SIZE_BITS_DEF  = 64;
	localparam int COUNT_BITS_DEF = 32;
	localparam int CONSUMED_W     = 32;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF_A = 8'h66;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;

	typedef enum logic [3:0] {
		PH_LEAD    = 4'd0,
		PH_DIG     = 4'd1,
		PH_TRAIL   = 4'd2,
		PH_EXT     = 4'd3,
		PH_DATA    = 4'd4,
		PH_END_CR  = 4'd5,
		PH_END_LF  = 4'd6,
		PH_TRAILER = 4'd7,
		PH_DONE    = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		ST_INCOMPLETE = 2'd0,
		ST_COMPLETE   = 2'd1,
		ST_MALFORMED  = 2'd2,
		ST_IGNORED    = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]            data_out;
		logic                  data_valid;
		status_t               status;
		logic [CONSUMED_W-1:0] consumed;
	} res_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	// Bit 4 flags a hex digit; bits 3:0 hold its value.
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [7:0] t;
		t = 8'h00;
		if ((b >= CH_0) && (b <= CH_9)) begin
			t = b - CH_0;
			return {1'b1, t[3:0]};
		end
		if ((b >= CH_LA) && (b <= CH_LF_A)) begin
			t = b - CH_LA + 8'd10;
			return {1'b1, t[3:0]};
		end
		if ((b >= CH_UA) && (b <= CH_UF)) begin
			t = b - CH_UA + 8'd10;
			return {1'b1, t[3:0]};
		end
		return 5'b0_0000;
	endfunction

endpackage

// ===== rtl/core/hcbd_core.sv =====
// Decoder state registers with the per-byte next-state and result logic.
module hcbd_core import hcbd_pkg::*; #(
	parameter int SIZE_BITS  = SIZE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_in,
	input  logic       begin_req,
	output res_t       res
);

	phase_t                phase_q, phase_d;
	logic [SIZE_BITS-1:0]  rem_q, rem_d;
	logic                  cr_q, cr_d;
	logic                  bad_q, bad_d;
	logic                  dig_q, dig_d;
	logic                  cont_q, cont_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;

	// State as seen by this byte, after an optional restart.
	phase_t                phase_e;
	logic [SIZE_BITS-1:0]  rem_e;
	logic                  cr_e, bad_e, dig_e, cont_e;
	logic [COUNT_BITS-1:0] cnt_e;

	logic [4:0]            hv;
	logic                  crlf_seen;
	logic [SIZE_BITS-1:0]  rem_dec;
	logic [63:0]           cnt_wide;

	always_comb begin
		if (begin_req) begin
			phase_e = PH_LEAD;
			rem_e   = '0;
			cr_e    = 1'b0;
			bad_e   = 1'b0;
			dig_e   = 1'b0;
			cont_e  = 1'b0;
			cnt_e   = '0;
		end else begin
			phase_e = phase_q;
			rem_e   = rem_q;
			cr_e    = cr_q;
			bad_e   = bad_q;
			dig_e   = dig_q;
			cont_e  = cont_q;
			cnt_e   = cnt_q;
		end
	end

	assign hv        = hex_val(data_in);
	assign crlf_seen = cr_e && (data_in == CH_LF);
	assign rem_dec   = rem_e - {{(SIZE_BITS-1){1'b0}}, 1'b1};

	// Next state.
	always_comb begin
		phase_d = phase_e;
		rem_d   = rem_e;
		cr_d    = cr_e;
		bad_d   = bad_e;
		dig_d   = dig_e;
		cont_d  = cont_e;
		cnt_d   = cnt_e;
		if (phase_e != PH_DONE) begin
			if (cnt_e != '1) begin
				cnt_d = cnt_e + {{(COUNT_BITS-1){1'b0}}, 1'b1};
			end
			unique case (phase_e)
				PH_LEAD, PH_DIG, PH_TRAIL, PH_EXT: begin
					cr_d = 1'b0;
					if (crlf_seen) begin
						if (bad_e || !dig_e) begin
							phase_d = PH_DONE;
						end else if (rem_e == '0) begin
							phase_d = PH_TRAILER;
							cont_d  = 1'b0;
						end else begin
							phase_d = PH_DATA;
						end
						bad_d = 1'b0;
						dig_d = 1'b0;
					end else if (phase_e == PH_EXT) begin
						cr_d = (data_in == CH_CR);
					end else if (data_in == CH_SEMI) begin
						phase_d = PH_EXT;
					end else if (is_ws(data_in)) begin
						if (phase_e == PH_DIG) begin
							phase_d = PH_TRAIL;
						end
						cr_d = (data_in == CH_CR);
					end else if (!hv[4] || (phase_e == PH_TRAIL)) begin
						bad_d = 1'b1;
					end else begin
						if (!bad_e) begin
							if (rem_e[SIZE_BITS-1 -: 4] != 4'h0) begin
								bad_d = 1'b1;
							end else begin
								rem_d = {rem_e[SIZE_BITS-5:0], hv[3:0]};
							end
						end
						dig_d   = 1'b1;
						phase_d = PH_DIG;
					end
				end
				PH_DATA: begin
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						phase_d = PH_END_CR;
					end
				end
				PH_END_CR: begin
					bad_d   = (data_in != CH_CR);
					phase_d = PH_END_LF;
				end
				PH_END_LF: begin
					if (bad_e || (data_in != CH_LF)) begin
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_LEAD;
						rem_d   = '0;
						cr_d    = 1'b0;
						bad_d   = 1'b0;
						dig_d   = 1'b0;
						cont_d  = 1'b0;
					end
				end
				PH_TRAILER: begin
					if (crlf_seen) begin
						cr_d = 1'b0;
						if (!cont_e) begin
							phase_d = PH_DONE;
						end else begin
							cont_d = 1'b0;
						end
					end else begin
						if (cr_e || (data_in != CH_CR)) begin
							cont_d = 1'b1;
						end
						cr_d = (data_in == CH_CR);
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end
	end

	// The count can be wider than the reported field, so it is clipped.
	assign cnt_wide = 64'(cnt_d);

	// Result for this byte.
	always_comb begin
		res.data_out   = 8'h00;
		res.data_valid = 1'b0;
		res.status     = ST_INCOMPLETE;
		res.consumed   = (cnt_wide > 64'h0000_0000_FFFF_FFFF) ? '1 :
			cnt_wide[CONSUMED_W-1:0];
		unique case (phase_e)
			PH_LEAD, PH_DIG, PH_TRAIL, PH_EXT: begin
				if (crlf_seen && (bad_e || !dig_e)) begin
					res.status = ST_MALFORMED;
				end
			end
			PH_DATA: begin
				res.data_out   = data_in;
				res.data_valid = 1'b1;
			end
			PH_END_CR: begin
				res.status = ST_INCOMPLETE;
			end
			PH_END_LF: begin
				if (bad_e || (data_in != CH_LF)) begin
					res.status = ST_MALFORMED;
				end
			end
			PH_TRAILER: begin
				if (crlf_seen && !cont_e) begin
					res.status = ST_COMPLETE;
				end
			end
			default: begin
				res.status = ST_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			rem_q   <= '0;
			cr_q    <= 1'b0;
			bad_q   <= 1'b0;
			dig_q   <= 1'b0;
			cont_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			cr_q    <= cr_d;
			bad_q   <= bad_d;
			dig_q   <= dig_d;
			cont_q  <= cont_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== rtl/core/http_chunked_body_decoder_top.sv =====
// Top level of the HTTP/1.1 chunked body decoder with its output register.
//
// Input channel: in_valid/in_ready carry one encoded body byte (data_in) per
// beat; begin_req high marks the first byte of a new body and restarts the
// decoder on that byte. Output channel: out_valid/out_ready carry one result
// per input beat: data_out/data_valid for payload bytes, status (incomplete,
// complete, malformed, ignored after end) and the saturating consumed count.
// The result is registered: a byte accepted at an edge shows its result from that
// edge on. Throughput is one byte per cycle while the receiver does not stall;
// the decode of a byte is a single pass of the phase logic plus one 64-bit size
// update between the state registers and the output register.
// If the receiver stalls, the result stays in the output register and
// in_ready follows out_ready, so a byte is taken in the same cycle that the
// waiting result leaves. Reset empties the output register and puts the
// decoder at the start of a size line with a zero count.
module http_chunked_body_decoder_top import hcbd_pkg::*; #(
	parameter int SIZE_BITS  = SIZE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_in,
	input  logic                  begin_req,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            data_out,
	output logic                  data_valid,
	output logic [1:0]            status,
	output logic [CONSUMED_W-1:0] consumed
);

	logic accept;
	res_t res;
	res_t res_q;
	logic out_valid_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	hcbd_core #(
		.SIZE_BITS (SIZE_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (accept),
		.data_in  (data_in),
		.begin_req(begin_req),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_out   = res_q.data_out;
	assign data_valid = res_q.data_valid;
	assign status     = res_q.status;
	assign consumed   = res_q.consumed;

`ifndef NO_ASSERTIONS
	a_payload_incomplete: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && data_valid) |-> (status == ST_INCOMPLETE))
		else $error("payload beat carries a final status");

	a_nonpayload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !data_valid) |-> (data_out == 8'h00))
		else $error("non-payload beat has nonzero data");

	a_restart_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && begin_req) |=> (out_valid && (consumed == 32'd1)))
		else $error("restart byte not counted as first");
`endif

endmodule
